>>> hdl/per_node_sequence_reorder_core_assert.svh
// Assertion macros used by the checker of the sequence reorder core.
`ifndef PER_NODE_SEQUENCE_REORDER_CORE_ASSERT_SVH
`define PER_NODE_SEQUENCE_REORDER_CORE_ASSERT_SVH

// Checked on every clock edge outside of reset.
`define PNSR_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define PNSR_CHECK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hdl/pnsr_pkg.sv
// Types and constants shared by the sequence reorder core.
package pnsr_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic KIND_SEND = 1'b0;
    localparam logic KIND_RECV = 1'b1;

    typedef enum logic [1:0] {
        ST_ACCEPT  = 2'd0,
        ST_REJECT  = 2'd1,
        ST_DELIVER = 2'd2,
        ST_DROP    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_DRAIN,
        S_CHK,
        S_WB,
        S_FIN
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [5:0]  node;
        logic [31:0] seq;
        logic [2:0]  vn;
        logic [31:0] tag;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] out_seq;
        logic [5:0]  out_node;
        logic [2:0]  out_vn;
        logic [31:0] out_tag;
        logic        last;
    } t_result;

    typedef struct packed {
        logic        valid;
        logic [2:0]  vn;
        logic [31:0] tag;
    } t_slot;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_push;

endpackage

>>> hdl/pnsr_out_reg.sv
// Output register stage that holds one result beat until it is taken.
module pnsr_out_reg
    import pnsr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_free,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out
);

    logic    r_valid;
    t_result r_data;

    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out       = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_push.valid) begin
            r_data <= i_push.data;
        end
    end

endmodule

>>> hdl/pnsr_engine.sv
// Sequencer with the per-node state memory and the reorder slot memory.
module pnsr_engine
    import pnsr_pkg::*;
#(
    parameter int NODES   = 64,
    parameter int WINDOW  = 16,
    parameter int MAX_VNS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [3:0] i_num_vns,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in,
    input  logic       i_out_free,
    output t_push      o_push
);

    localparam int NODE_AW = $clog2(NODES);
    localparam int HEAD_W  = $clog2(WINDOW);
    localparam int SLOTS   = NODES * WINDOW;
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int NENT_W  = 64 + HEAD_W;

    logic [NENT_W-1:0] node_mem [NODES];
    t_slot             slot_mem [SLOTS];

    t_state             r_state, n_state;
    logic [SLOT_AW-1:0] r_clr, n_clr;
    t_in_item           r_item, n_item;
    logic [SLOT_AW-1:0] r_base, n_base;
    logic [NODE_AW-1:0] r_node_idx, n_node_idx;
    logic               r_in_range, n_in_range;
    logic [31:0]        r_ctr, n_ctr;
    logic [31:0]        r_exp, n_exp;
    logic [HEAD_W-1:0]  r_head, n_head;
    logic               r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [HEAD_W-1:0]  r_phys, n_phys;
    logic               r_dist0, n_dist0;
    logic               r_pend_v, n_pend_v;
    t_result            r_pend, n_pend;

    logic [NENT_W-1:0]  r_node_rd;
    t_slot              r_slot_rd;

    logic               node_we;
    logic [NODE_AW-1:0] node_waddr, node_raddr;
    logic [NENT_W-1:0]  node_wdata;
    logic               slot_we;
    logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
    t_slot              slot_wdata;

    logic               accept;
    logic               is_send;
    logic               can_put;
    logic               put;
    t_result            put_res;
    logic [CNT_W-1:0]   lim;
    logic               drain_go;
    logic [31:0]        delta;
    logic               far;
    logic [HEAD_W:0]    phys_sum;
    logic [HEAD_W-1:0]  phys;
    logic [HEAD_W-1:0]  head_inc;
    logic               vn_ok;
    logic [31:0]        rd_ctr, rd_exp;
    logic [HEAD_W-1:0]  rd_head;

    function automatic t_result mk_res(t_status st, logic [31:0] sq, logic [5:0] nd,
                                       logic [2:0] v, logic [31:0] tg);
        t_result res;
        res.status   = st;
        res.out_seq  = sq;
        res.out_node = nd;
        res.out_vn   = v;
        res.out_tag  = tg;
        res.last     = 1'b0;
        return res;
    endfunction

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign is_send    = (r_item.kind == KIND_SEND);
    assign can_put    = !r_pend_v || i_out_free;
    assign lim        = r_phase ? CNT_W'(MAX_RESULTS) : CNT_W'(MAX_RESULTS - 1);
    assign drain_go   = r_slot_rd.valid && (r_cnt < lim);
    assign delta      = r_item.seq - r_exp;
    assign far        = (delta >= 32'(WINDOW));
    assign phys_sum   = {1'b0, r_head} + {1'b0, delta[HEAD_W-1:0]};
    assign phys       = (phys_sum >= (HEAD_W+1)'(WINDOW)) ?
                        HEAD_W'(phys_sum - (HEAD_W+1)'(WINDOW)) : phys_sum[HEAD_W-1:0];
    assign head_inc   = (r_head == HEAD_W'(WINDOW - 1)) ? '0 : r_head + 1'b1;
    assign vn_ok      = ({1'b0, r_item.vn} < i_num_vns) && (32'(r_item.vn) < MAX_VNS);
    assign rd_ctr     = r_node_rd[NENT_W-1 -: 32];
    assign rd_exp     = r_node_rd[HEAD_W +: 32];
    assign rd_head    = r_node_rd[HEAD_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == SLOT_AW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (!r_in_range) begin
                    n_state = S_FIN;
                end else if (is_send) begin
                    n_state = S_WB;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (can_put && !drain_go) begin
                    if (r_phase || far) begin
                        n_state = S_WB;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (can_put) begin
                    if (!r_slot_rd.valid && r_dist0) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_WB;
                    end
                end
            end
            S_WB: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_pend_v || i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_clr      = r_clr;
        n_item     = r_item;
        n_base     = r_base;
        n_node_idx = r_node_idx;
        n_in_range = r_in_range;
        n_ctr      = r_ctr;
        n_exp      = r_exp;
        n_head     = r_head;
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_phys     = r_phys;
        n_dist0    = r_dist0;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        node_we    = 1'b0;
        node_waddr = r_node_idx;
        node_wdata = {r_ctr, r_exp, r_head};
        node_raddr = NODE_AW'(i_in.node);
        slot_we    = 1'b0;
        slot_waddr = r_base + SLOT_AW'(r_head);
        slot_wdata = '0;
        slot_raddr = r_base + SLOT_AW'(r_head);
        put        = 1'b0;
        put_res    = '0;
        o_push     = '0;

        case (r_state)
            S_CLEAR: begin
                node_we    = (r_clr < SLOT_AW'(NODES));
                node_waddr = r_clr[NODE_AW-1:0];
                node_wdata = '0;
                slot_we    = 1'b1;
                slot_waddr = r_clr;
                n_clr      = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    n_item     = i_in;
                    n_node_idx = NODE_AW'(i_in.node);
                    n_base     = SLOT_AW'(NODE_AW'(i_in.node)) * SLOT_AW'(WINDOW);
                    n_in_range = (32'(i_in.node) < NODES);
                    n_cnt      = '0;
                    n_phase    = 1'b0;
                end
            end
            S_LOOK: begin
                n_ctr      = rd_ctr;
                n_exp      = rd_exp;
                n_head     = rd_head;
                slot_raddr = r_base + SLOT_AW'(rd_head);
                if (!r_in_range) begin
                    put = 1'b1;
                    if (is_send) begin
                        put_res = mk_res(ST_REJECT, '0, r_item.node, r_item.vn, '0);
                    end else begin
                        put_res = mk_res(ST_DROP, r_item.seq, r_item.node, r_item.vn,
                                         r_item.tag);
                    end
                end else if (is_send) begin
                    put = 1'b1;
                    if (vn_ok) begin
                        put_res = mk_res(ST_ACCEPT, rd_ctr, r_item.node, r_item.vn, '0);
                        n_ctr   = rd_ctr + 1'b1;
                    end else begin
                        put_res = mk_res(ST_REJECT, '0, r_item.node, r_item.vn, '0);
                    end
                end
            end
            S_DRAIN: begin
                if (can_put) begin
                    if (drain_go) begin
                        put        = 1'b1;
                        put_res    = mk_res(ST_DELIVER, r_exp, r_item.node,
                                            r_slot_rd.vn, r_slot_rd.tag);
                        slot_we    = 1'b1;
                        n_exp      = r_exp + 1'b1;
                        n_head     = head_inc;
                        n_cnt      = r_cnt + 1'b1;
                        slot_raddr = r_base + SLOT_AW'(head_inc);
                    end else if (!r_phase) begin
                        if (far) begin
                            put     = 1'b1;
                            put_res = mk_res(ST_DROP, r_item.seq, r_item.node, r_item.vn,
                                             r_item.tag);
                        end else begin
                            slot_raddr = r_base + SLOT_AW'(phys);
                            n_phys     = phys;
                            n_dist0    = (delta == '0);
                        end
                    end
                end
            end
            S_CHK: begin
                slot_raddr = r_base + SLOT_AW'(r_phys);
                slot_waddr = r_base + SLOT_AW'(r_phys);
                if (can_put) begin
                    if (r_slot_rd.valid) begin
                        put     = 1'b1;
                        put_res = mk_res(ST_DROP, r_item.seq, r_item.node, r_item.vn,
                                         r_item.tag);
                    end else if (r_dist0) begin
                        put        = 1'b1;
                        put_res    = mk_res(ST_DELIVER, r_item.seq, r_item.node,
                                            r_item.vn, r_item.tag);
                        n_exp      = r_exp + 1'b1;
                        n_head     = head_inc;
                        n_cnt      = r_cnt + 1'b1;
                        n_phase    = 1'b1;
                        slot_raddr = r_base + SLOT_AW'(head_inc);
                    end else begin
                        slot_we          = 1'b1;
                        slot_wdata.valid = 1'b1;
                        slot_wdata.vn    = r_item.vn;
                        slot_wdata.tag   = r_item.tag;
                    end
                end
            end
            S_WB: begin
                node_we = 1'b1;
            end
            S_FIN: begin
                if (r_pend_v && i_out_free) begin
                    o_push.valid     = 1'b1;
                    o_push.data      = r_pend;
                    o_push.data.last = 1'b1;
                    n_pend_v         = 1'b0;
                end
            end
            default: begin
                n_pend_v = 1'b0;
            end
        endcase

        if (put) begin
            if (r_pend_v) begin
                o_push.valid = 1'b1;
                o_push.data  = r_pend;
            end
            n_pend   = put_res;
            n_pend_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        r_node_rd <= node_mem[node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        r_slot_rd <= slot_mem[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_base     <= n_base;
        r_node_idx <= n_node_idx;
        r_in_range <= n_in_range;
        r_ctr      <= n_ctr;
        r_exp      <= n_exp;
        r_head     <= n_head;
        r_phase    <= n_phase;
        r_cnt      <= n_cnt;
        r_phys     <= n_phys;
        r_dist0    <= n_dist0;
        r_pend     <= n_pend;
    end

endmodule

>>> hdl/per_node_sequence_reorder_core.sv
// Top level of the per-node send sequencer and receive reorder buffer.
//
// Items are taken one at a time: the next item is accepted only once the
// last one is finished. A receive is dropped as stale or too far, parked,
// dropped as a duplicate, or delivered in order, and held packets are
// released ahead of it or behind it; each released packet costs one
// read-modify-write of the slot memory, which has one read and one write
// port. An item whose node lies at or above NODES is answered without the
// slot memory. Output stalls hold the sequencer while a result beat waits.
// Per-node counters, expected sequence numbers and window positions live
// in one memory, the reorder slots in a second one. After reset the block
// sweeps both memories, during which it accepts no item; configuration
// writes are taken as ever.
module per_node_sequence_reorder_core
    import pnsr_pkg::*;
#(
    parameter int NODES   = 64,
    parameter int WINDOW  = 16,
    parameter int MAX_VNS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_result    o_out
);

    logic [3:0] r_num_vns;
    t_push      push;
    logic       out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vns <= 4'd1;
        end else if (i_cfg_we) begin
            r_num_vns <= i_cfg_data;
        end
    end

    pnsr_engine #(
        .NODES   (NODES),
        .WINDOW  (WINDOW),
        .MAX_VNS (MAX_VNS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_num_vns  (r_num_vns),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_out_free (out_free),
        .o_push     (push)
    );

    pnsr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

>>> hdl/pnsr_checker.sv
// Port-level checker for the sequence reorder core and its bind statement.
`include "per_node_sequence_reorder_core_assert.svh"

module pnsr_checker
    import pnsr_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    o_in_stall,
    input logic    o_out_valid,
    input logic    i_out_stall,
    input t_result o_out
);

    `PNSR_CHECK_RST(a_reset_sweep, !i_rst_n |=> o_in_stall && !o_out_valid, "Block not held idle after reset.")

    `PNSR_CHECK(a_one_item, i_in_valid && !o_in_stall |=> o_in_stall, "Input taken while an item is in work.")

    `PNSR_CHECK(a_send_single, o_out_valid && (o_out.status == ST_ACCEPT || o_out.status == ST_REJECT) |-> o_out.last, "Send result beat is not marked last.")

    `PNSR_CHECK(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out), "Stalled output beat changed.")

endmodule

bind per_node_sequence_reorder_core pnsr_checker u_chk (.*);
